### design/cfpsa_pkg.sv
// ----------------------------------------------------------------------------
// cfpsa_pkg
// Shared types, constants and arithmetic helpers of the cube-face pixel to
// sphere angles pipeline.
// ----------------------------------------------------------------------------
package cfpsa_pkg;

   localparam int MAX_FACE_SIZE = 1024;
   localparam logic [10:0] FACE_SIZE_RESET = 11'd1024;

   localparam int CORDIC_STEPS = 20;
   localparam int SQRT_STEPS   = 30;

   // pipeline stage indexes
   localparam int ST_INIT     = 1;
   localparam int ST_SQRT0    = 2;
   localparam int ST_POL_INIT = ST_SQRT0 + SQRT_STEPS;
   localparam int ST_POL0     = ST_POL_INIT + 1;
   localparam int ST_LAST     = ST_POL0 + CORDIC_STEPS - 1;
   localparam int ST_COUNT    = ST_LAST + 1;

   // face codes
   localparam logic [2:0] FACE_FRONT  = 3'd0;
   localparam logic [2:0] FACE_BACK   = 3'd1;
   localparam logic [2:0] FACE_TOP    = 3'd2;
   localparam logic [2:0] FACE_BOTTOM = 3'd3;
   localparam logic [2:0] FACE_LEFT   = 3'd4;
   localparam logic [2:0] FACE_RIGHT  = 3'd5;

   typedef logic signed [33:0] vec_type;
   typedef logic signed [27:0] ang_type;
   typedef logic signed [17:0] q13_type;

   localparam ang_type PI_Q24 = 28'sd52707179;
   localparam q13_type AZ_MAX = 18'sd25736;

   localparam ang_type ATAN_Q24 [CORDIC_STEPS] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
      28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024,
      28'sd512, 28'sd256, 28'sd128, 28'sd64, 28'sd32
   };

   typedef struct packed {
      vec_type x;
      vec_type y;
      ang_type acc;
   } cordic_type;

   typedef struct packed {
      logic               vld;
      logic               bad;
      logic [11:0]        oc;
      logic [10:0]        orow;
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic signed [11:0] z;
      logic [23:0]        s;
      logic [32:0]        rem;
      logic [29:0]        root;
      cordic_type         az;
      cordic_type         pol;
   } stage_type;

   // fold the left half plane onto the right one
   function automatic cordic_type cordic_pre(vec_type y, vec_type x);
      cordic_type c;
      c.x   = x;
      c.y   = y;
      c.acc = '0;
      if (x < 0) begin
         c.acc = (y >= 0) ? PI_Q24 : -PI_Q24;
         c.x   = -x;
         c.y   = -y;
      end
      return c;
   endfunction

   function automatic cordic_type cordic_step(cordic_type c, int k);
      cordic_type r;
      vec_type    dx;
      vec_type    dy;
      dx = c.x >>> k;
      dy = c.y >>> k;
      if (c.y >= 0) begin
         r.x   = c.x + dy;
         r.y   = c.y - dx;
         r.acc = c.acc + ATAN_Q24[k];
      end else begin
         r.x   = c.x - dy;
         r.y   = c.y + dx;
         r.acc = c.acc - ATAN_Q24[k];
      end
      return r;
   endfunction

   // Q.24 to rounded Q3.13 with clamp
   function automatic q13_type to_q13(ang_type a, q13_type lo, q13_type hi);
      logic signed [28:0] t;
      q13_type            r;
      t = 29'(a) + 29'sd1024;
      r = 18'(t >>> 11);
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

endpackage

### design/cfpsa_if.sv
// ----------------------------------------------------------------------------
// cfpsa channel interfaces
// Valid/ready channels for pixel requests, angle responses and the face size
// register write.
// ----------------------------------------------------------------------------
interface cfpsa_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] col_index;
   logic [9:0] row_index;
   logic [2:0] face;
   modport source (output valid, col_index, row_index, face, input ready);
   modport sink   (input valid, col_index, row_index, face, output ready);
endinterface

interface cfpsa_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        out_col;
   logic [10:0]        out_row;
   logic signed [15:0] azimuth;
   logic [14:0]        polar;
   modport source (output valid, out_col, out_row, azimuth, polar, input ready);
   modport sink   (input valid, out_col, out_row, azimuth, polar, output ready);
endinterface

interface cfpsa_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### design/cube_face_pixel_to_sphere_angles.sv
// ----------------------------------------------------------------------------
// cube_face_pixel_to_sphere_angles
// Maps a cube-face pixel to its azimuth and polar angle and to its place in
// a 3x2 cube layout image.
//
// req carries one pixel (col_index, row_index, face) per transaction, rsp
// returns out_col, out_row, azimuth and polar (Q3.13 radians) in order.
// csr writes the face size and is always ready; the user must write it
// only while idle, which the block does not enforce. The pipeline is 54
// register stages: input decode, x*x+y*y, 30 stages of restoring square
// root (one root bit each) with the 20 azimuth CORDIC steps alongside,
// polar setup, 20 polar CORDIC steps and the output register. One
// transaction is taken per cycle while rsp is not held off.
// When rsp is held off the whole pipeline freezes and req.ready drops; it
// resumes with nothing lost. Reset clears all valid bits and sets the face
// size to 1024. Face codes six and seven give an all-zero result.
// ----------------------------------------------------------------------------
module cube_face_pixel_to_sphere_angles (
   input logic          clock,
   input logic          reset,
   cfpsa_csr_if.sink    csr,
   cfpsa_req_if.sink    req,
   cfpsa_rsp_if.source  rsp
);
   import cfpsa_pkg::*;

   logic        adv;
   logic [10:0] face_size_ff;
   stage_type   st_ff [ST_COUNT];
   stage_type   st_in [ST_COUNT];

   logic               rsp_valid_ff;
   logic [11:0]        out_col_ff;
   logic [10:0]        out_row_ff;
   logic signed [15:0] azimuth_ff;
   logic [14:0]        polar_ff;
   q13_type            az_q;
   q13_type            pol_q;

   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= FACE_SIZE_RESET;
      end else if (csr.valid) begin
         face_size_ff <= csr.data;
      end
   end

   // decode face into direction and layout position
   always_comb begin
      logic [10:0]        n;
      logic signed [11:0] u;
      logic signed [11:0] v;
      logic signed [11:0] e;
      logic [11:0]        col;
      logic [11:0]        n1;
      logic [11:0]        n2;
      n = face_size_ff;
      if (n == 11'd0) n = 11'd1;
      else if (n > 11'(MAX_FACE_SIZE)) n = 11'(MAX_FACE_SIZE);
      col = {2'b00, req.col_index};
      n1  = {1'b0, n};
      n2  = {n, 1'b0};
      u   = {1'b0, req.col_index, 1'b0} - n1;
      v   = {1'b0, req.row_index, 1'b0} - n1;
      e   = n1;
      st_in[0]      = '0;
      st_in[0].vld  = req.valid;
      st_in[0].orow = {1'b0, req.row_index};
      st_in[0].oc   = col;
      case (req.face)
         FACE_FRONT: begin
            st_in[0].x = e;  st_in[0].y = u;  st_in[0].z = v;
         end
         FACE_BACK: begin
            st_in[0].x = -e; st_in[0].y = -u; st_in[0].z = v;
            st_in[0].orow = {1'b0, req.row_index} + n;
         end
         FACE_TOP: begin
            st_in[0].x = v;  st_in[0].y = u;  st_in[0].z = -e;
            st_in[0].oc = col + n2;
         end
         FACE_BOTTOM: begin
            st_in[0].x = -v; st_in[0].y = u;  st_in[0].z = e;
            st_in[0].oc = col + n2;
            st_in[0].orow = {1'b0, req.row_index} + n;
         end
         FACE_LEFT: begin
            st_in[0].x = -u; st_in[0].y = e;  st_in[0].z = v;
            st_in[0].oc = col + n1;
         end
         FACE_RIGHT: begin
            st_in[0].x = u;  st_in[0].y = -e; st_in[0].z = v;
            st_in[0].oc = col + n1;
            st_in[0].orow = {1'b0, req.row_index} + n;
         end
         default: begin
            st_in[0].bad = 1'b1;
         end
      endcase
   end

   for (genvar g = 1; g < ST_COUNT; g++) begin : g_stage
      if (g == ST_INIT) begin : g_init
         always_comb begin
            logic [23:0] xx;
            logic [23:0] yy;
            xx = 24'(st_ff[g-1].x * st_ff[g-1].x);
            yy = 24'(st_ff[g-1].y * st_ff[g-1].y);
            st_in[g]      = st_ff[g-1];
            st_in[g].s    = xx + yy;
            st_in[g].rem  = '0;
            st_in[g].root = '0;
            st_in[g].az   = cordic_pre(vec_type'(st_ff[g-1].y) <<< 18,
                                       vec_type'(st_ff[g-1].x) <<< 18);
         end
      end else if (g < ST_POL_INIT) begin : g_sqrt
         // root bit j consumes bits 2j+1:2j of s shifted left by 36
         localparam int J    = SQRT_STEPS - 1 - (g - ST_SQRT0);
         localparam int PIDX = (J >= 18) ? 2*J-36 : 0;
         always_comb begin
            logic [1:0]  pair;
            logic [32:0] rem_n;
            logic [32:0] trial;
            pair = '0;
            if (J >= 18) pair = st_ff[g-1].s[PIDX +: 2];
            rem_n = {st_ff[g-1].rem[30:0], pair};
            trial = {1'b0, st_ff[g-1].root, 2'b01};
            st_in[g] = st_ff[g-1];
            if (rem_n >= trial) begin
               st_in[g].rem  = rem_n - trial;
               st_in[g].root = {st_ff[g-1].root[28:0], 1'b1};
            end else begin
               st_in[g].rem  = rem_n;
               st_in[g].root = {st_ff[g-1].root[28:0], 1'b0};
            end
            if (g - ST_SQRT0 < CORDIC_STEPS) begin
               st_in[g].az = cordic_step(st_ff[g-1].az, g - ST_SQRT0);
            end
         end
      end else if (g == ST_POL_INIT) begin : g_pol_init
         always_comb begin
            st_in[g]     = st_ff[g-1];
            st_in[g].pol = cordic_pre(vec_type'({4'b0000, st_ff[g-1].root}),
                                      vec_type'(st_ff[g-1].z) <<< 18);
         end
      end else begin : g_pol
         always_comb begin
            st_in[g]     = st_ff[g-1];
            st_in[g].pol = cordic_step(st_ff[g-1].pol, g - ST_POL0);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ST_COUNT; i++) begin
         if (reset) begin
            st_ff[i].vld <= 1'b0;
         end else if (adv) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign az_q  = to_q13(st_ff[ST_LAST].az.acc, -AZ_MAX, AZ_MAX);
   assign pol_q = to_q13(st_ff[ST_LAST].pol.acc, 18'sd0, AZ_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= st_ff[ST_LAST].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (st_ff[ST_LAST].bad) begin
            out_col_ff <= '0;
            out_row_ff <= '0;
            azimuth_ff <= '0;
            polar_ff   <= '0;
         end else begin
            out_col_ff <= st_ff[ST_LAST].oc;
            out_row_ff <= st_ff[ST_LAST].orow;
            azimuth_ff <= 16'(az_q);
            polar_ff   <= 15'(pol_q);
         end
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.out_col = out_col_ff;
   assign rsp.out_row = out_row_ff;
   assign rsp.azimuth = azimuth_ff;
   assign rsp.polar   = polar_ff;

   a_in_enters: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> st_ff[0].vld)
      else $error("accepted transaction missing from first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(st_ff[ST_LAST]))
      else $error("last stage changed during stall");

   a_az_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.azimuth >= -16'sd25736 && rsp.azimuth <= 16'sd25736))
      else $error("azimuth out of range");

   a_pol_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.polar <= 15'd25736))
      else $error("polar out of range");

endmodule

### bench/cfpsa_checker.sv
// ----------------------------------------------------------------------------
// cfpsa_checker
// Watches the request, response and face size channels of the cube-face pixel
// to sphere angles block, predicts each response with an integer CORDIC model
// and compares the responses field by field, in order.
// ----------------------------------------------------------------------------
module cfpsa_checker (
   input  logic       clock,
   input  logic       reset,
   cfpsa_csr_if       csr,
   cfpsa_req_if       req,
   cfpsa_rsp_if       rsp,
   output int         fail_count,
   output int         pending
);
   import cfpsa_pkg::*;

   typedef struct {
      logic [11:0]        col;
      logic [10:0]        row;
      logic signed [15:0] az;
      logic [14:0]        pol;
   } angles_type;

   angles_type        expected_angles[$];
   logic [10:0]       edge_len;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint isqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint acc;
      longint dx;
      longint dy;
      acc = 0;
      if (x < 0) begin
         acc = (y >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
         x = -x;
         y = -y;
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         dx = shr_floor(x, k);
         dy = shr_floor(y, k);
         if (y >= 0) begin
            x   = x + dy;
            y   = y - dx;
            acc = acc + longint'(ATAN_Q24[k]);
         end else begin
            x   = x - dy;
            y   = y + dx;
            acc = acc - longint'(ATAN_Q24[k]);
         end
      end
      return acc;
   endfunction

   function automatic longint round_q13(longint a, longint lo, longint hi);
      longint r;
      r = shr_floor(a + 1024, 11);
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   function automatic angles_type predict_angles(logic [9:0] c, logic [9:0] r,
                                                 logic [2:0] f, logic [10:0] fs);
      angles_type a;
      longint n, u, v, x, y, z, oc, orow, rad;
      n = fs;
      if (n < 1) n = 1;
      if (n > MAX_FACE_SIZE) n = MAX_FACE_SIZE;
      u = 2 * longint'(c) - n;
      v = 2 * longint'(r) - n;
      a = '{default: '0};
      case (f)
         FACE_FRONT:  begin x = n;  y = u;  z = v;  oc = c;         orow = r;     end
         FACE_BACK:   begin x = -n; y = -u; z = v;  oc = c;         orow = r + n; end
         FACE_TOP:    begin x = v;  y = u;  z = -n; oc = c + 2 * n; orow = r;     end
         FACE_BOTTOM: begin x = -v; y = u;  z = n;  oc = c + 2 * n; orow = r + n; end
         FACE_LEFT:   begin x = -u; y = n;  z = v;  oc = c + n;     orow = r;     end
         FACE_RIGHT:  begin x = u;  y = -n; z = v;  oc = c + n;     orow = r + n; end
         default:     return a;
      endcase
      rad   = isqrt(longint'(x * x + y * y) << 36);
      a.col = 12'(oc);
      a.row = 11'(orow);
      a.az  = 16'(round_q13(vector_angle(y * 262144, x * 262144), -25736, 25736));
      a.pol = 15'(round_q13(vector_angle(rad, z * 262144), 0, 25736));
      return a;
   endfunction

   always @(posedge clock) begin
      angles_type e;
      if (reset) begin
         edge_len = FACE_SIZE_RESET;
         expected_angles.delete();
         fail_count = 0;
      end else begin
         if (req.valid && req.ready)
            expected_angles.push_back(predict_angles(req.col_index, req.row_index,
                                                     req.face, edge_len));
         if (rsp.valid && rsp.ready) begin
            if (expected_angles.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response transaction");
            end else begin
               e = expected_angles.pop_front();
               if (rsp.out_col !== e.col || rsp.out_row !== e.row ||
                   rsp.azimuth !== e.az || rsp.polar !== e.pol) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp col %0d row %0d az %0d pol %0d, got %0d %0d %0d %0d",
                              e.col, e.row, e.az, e.pol, rsp.out_col, rsp.out_row,
                              rsp.azimuth, rsp.polar);
               end
            end
         end
         if (csr.valid && csr.ready) edge_len = csr.data;
      end
      pending = expected_angles.size();
   end

endmodule

### bench/tb_cube_face_pixel_to_sphere_angles.sv
// ----------------------------------------------------------------------------
// tb_cube_face_pixel_to_sphere_angles
// Drives directed and random pixels through several face sizes with random
// gaps and response stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_cube_face_pixel_to_sphere_angles;
   import cfpsa_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_cycles;
   bit   long_hold;
   logic [10:0] cur_size;

   cfpsa_csr_if csr ();
   cfpsa_req_if req ();
   cfpsa_rsp_if rsp ();

   cube_face_pixel_to_sphere_angles dut (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .req   (req),
      .rsp   (rsp)
   );

   cfpsa_checker chk (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .req        (req),
      .rsp        (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // one pixel transaction, with a random gap in front of it when gaps is set
   task automatic send_pixel(logic [9:0] c, logic [9:0] r, logic [2:0] f, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.col_index <= c;
      req.row_index <= r;
      req.face      <= f;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic write_size(logic [10:0] s);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= s;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      cur_size = s;
   endtask

   task automatic random_pixel();
      logic [9:0] c, r;
      logic [2:0] f;
      int lim;
      lim = (cur_size == 0) ? 1 : (cur_size > 1024 ? 1024 : int'(cur_size));
      if ($urandom_range(0, 9) == 0) begin
         c = 10'($urandom);
         r = 10'($urandom);
         f = 3'($urandom);
      end else begin
         c = 10'($urandom_range(0, lim - 1));
         r = 10'($urandom_range(0, lim - 1));
         f = 3'($urandom_range(FACE_FRONT, FACE_RIGHT));
      end
      send_pixel(c, r, f, 1'b1);
   endtask

   // response side: random stalls, and one long hold-off
   initial begin
      int g;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp.ready <= 1'b0;
            repeat (150) @(posedge clock);
            long_hold = 1'b0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // watchdog on cycles with no transaction
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
             (csr.valid && csr.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 5000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [10:0] sizes [6];
      sizes = '{11'd1, 11'd2047, 11'd0, 11'd7, 11'd1024, 11'd64};
      long_hold     = 1'b0;
      cur_size      = FACE_SIZE_RESET;
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.col_index <= '0;
      req.row_index <= '0;
      req.face      <= '0;
      csr.valid     <= 1'b0;
      csr.data      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, centers, every face, bad face codes, out-of-range index
      for (int f = FACE_FRONT; f <= FACE_RIGHT; f++) begin
         send_pixel(10'd0, 10'd0, 3'(f), 1'b0);
         send_pixel(10'd1023, 10'd1023, 3'(f), 1'b0);
         send_pixel(10'd512, 10'd512, 3'(f), 1'b0);
      end
      send_pixel(10'd5, 10'd900, 3'd6, 1'b0);
      send_pixel(10'd1023, 10'd0, 3'd7, 1'b0);
      send_pixel(10'd0, 10'd1023, FACE_TOP, 1'b0);
      write_size(11'd3);
      send_pixel(10'd1023, 10'd1023, FACE_BOTTOM, 1'b0);
      send_pixel(10'd700, 10'd5, FACE_RIGHT, 1'b0);

      // keep offering while the response side holds off
      long_hold = 1'b1;
      for (int i = 0; i < 100; i++) random_pixel();

      foreach (sizes[s]) begin
         write_size(sizes[s]);
         for (int i = 0; i < 140; i++) random_pixel();
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### filelist.f
design/cfpsa_pkg.sv
design/cfpsa_if.sv
design/cube_face_pixel_to_sphere_angles.sv
bench/cfpsa_checker.sv
bench/tb_cube_face_pixel_to_sphere_angles.sv
